// File: hdl/rbc_pkg.sv
// rbc_pkg: shared types, sizes and codes for the buffer cache block.
// Used by rbc_front, rbc_back and refcounted_block_buffer_cache.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbc_pkg;

   // Pool size and the index width that follows from it
   localparam int NUM_SLOTS = 32;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // Fixed field widths
   localparam int OPC_W  = 2;
   localparam int DEV_W  = 8;
   localparam int BLK_W  = 32;
   localparam int SLOT_W = 5;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 8;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   // Decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef enum logic [OPC_W-1:0] {
      OP_GET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PIN     = 2'd2,
      OP_UNPIN   = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_ERROR   = 2'd2
   } status_type;

   typedef enum logic {
      BK_LOOK   = 1'b0,
      BK_COMMIT = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [OPC_W-1:0]  opcode;
      logic [DEV_W-1:0]  device;
      logic [BLK_W-1:0]  block_number;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_out;
      logic              needs_read;
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  count_out;
   } rsp_type;

   // Decoded view of a request, made once at the front
   typedef struct packed {
      op_type           kind;
      logic             slot_oob;
      logic [IDX_W-1:0] idx;
   } cls_type;

   typedef struct packed {
      req_type req;
      cls_type cls;
   } q_item_type;

endpackage

`default_nettype wire

// File: hdl/rbc_front.sv
// rbc_front: request decode and the short queue that feeds the back end.
// Depends on rbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire rbc_pkg::req_type    req_data,
   output logic                     q_valid,
   output rbc_pkg::q_item_type      q_item,
   input  wire logic                q_pop
);
   import rbc_pkg::*;

   q_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   q_item_type        new_item;
   logic              push, pop;

   // Decode
   always_comb begin
      new_item.req          = req_data;
      new_item.cls.kind     = op_type'(req_data.opcode);
      new_item.cls.slot_oob = (32'(req_data.slot) >= 32'(NUM_SLOTS));
      new_item.cls.idx      = IDX_W'(req_data.slot);
   end

   assign req_stall = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_valid   = (fill_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];
   assign push      = req_valid & ~req_stall;
   assign pop       = q_pop & q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

// File: hdl/rbc_back.sv
// rbc_back: slot table, tag lookup and reference count update.
// Two steps per request: look (tag compare, free search), commit.
// Depends on rbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire rbc_pkg::q_item_type q_item,
   output logic                     q_pop,
   output logic                     res_valid,
   output rbc_pkg::rsp_type         res_data,
   input  wire logic                res_ready
);
   import rbc_pkg::*;

   // Slot table
   logic [NUM_SLOTS-1:0] used_ff, used_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]     count_ff [NUM_SLOTS];
   logic [CNT_W-1:0]     count_in [NUM_SLOTS];
   logic [DEV_W-1:0]     dev_ff   [NUM_SLOTS];
   logic [BLK_W-1:0]     blk_ff   [NUM_SLOTS];

   // Sequencer and look results
   back_state_type       state_ff, state_in;
   q_item_type           cur_ff;
   logic                 hit_any_ff, free_any_ff;
   logic [IDX_W-1:0]     hit_idx_ff, free_idx_ff;

   logic [NUM_SLOTS-1:0] hit_vec, free_vec;
   logic                 hit_any, free_any;
   logic [IDX_W-1:0]     hit_idx, free_idx;
   logic                 look_en, commit;

   // Commit datapath
   logic [IDX_W-1:0]     act_idx;
   logic [CNT_W-1:0]     cnt, cnt_new;
   logic                 cnt_we, claim, set_valid, free_slot;
   rsp_type              res;

   // Look: full tag compare and lowest free slot
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         hit_vec[i] = used_ff[i] && (dev_ff[i] == q_item.req.device)
                      && (blk_ff[i] == q_item.req.block_number);
      end
      free_vec = ~used_ff;
      hit_any  = |hit_vec;
      free_any = |free_vec;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = NUM_SLOTS-1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (free_vec[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      look_en   = 1'b0;
      res_valid = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         BK_LOOK: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               look_en  = 1'b1;
               state_in = BK_COMMIT;
            end
         end
         BK_COMMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               commit   = 1'b1;
               state_in = BK_LOOK;
            end
         end
         default: state_in = BK_LOOK;
      endcase
   end

   // Commit: result and table update
   always_comb begin
      if (cur_ff.cls.kind == OP_GET) begin
         act_idx = hit_any_ff ? hit_idx_ff : free_idx_ff;
      end else begin
         act_idx = cur_ff.cls.idx;
      end
      cnt           = count_ff[act_idx];
      cnt_new       = cnt;
      cnt_we        = 1'b0;
      claim         = 1'b0;
      set_valid     = 1'b0;
      free_slot     = 1'b0;
      res.slot_out   = cur_ff.req.slot;
      res.needs_read = 1'b0;
      res.status     = ST_OK;
      res.count_out  = cnt;
      case (cur_ff.cls.kind)
         OP_GET: begin
            if (hit_any_ff) begin
               res.slot_out = SLOT_W'(hit_idx_ff);
               if (cnt == CNT_MAX) begin
                  res.status = ST_ERROR;
               end else begin
                  cnt_we         = 1'b1;
                  cnt_new        = cnt + 1'b1;
                  set_valid      = 1'b1;
                  res.needs_read = ~valid_ff[act_idx];
                  res.count_out  = cnt + 1'b1;
               end
            end else if (free_any_ff) begin
               res.slot_out   = SLOT_W'(free_idx_ff);
               claim          = 1'b1;
               cnt_we         = 1'b1;
               cnt_new        = CNT_ONE;
               set_valid      = 1'b1;
               res.needs_read = 1'b1;
               res.count_out  = CNT_ONE;
            end else begin
               res.slot_out  = '0;
               res.status    = ST_NO_FREE;
               res.count_out = '0;
            end
         end
         OP_RELEASE, OP_PIN, OP_UNPIN: begin
            if (cur_ff.cls.slot_oob) begin
               res.status    = ST_ERROR;
               res.count_out = '0;
            end else if (!used_ff[act_idx]) begin
               res.status = ST_ERROR;
            end else if (cur_ff.cls.kind == OP_PIN) begin
               if (cnt == CNT_MAX) begin
                  res.status = ST_ERROR;
               end else begin
                  cnt_we        = 1'b1;
                  cnt_new       = cnt + 1'b1;
                  res.count_out = cnt + 1'b1;
               end
            end else begin
               if (cnt == '0) begin
                  res.status = ST_ERROR;
               end else begin
                  cnt_we        = 1'b1;
                  cnt_new       = cnt - 1'b1;
                  res.count_out = cnt - 1'b1;
                  // release to zero frees the slot, unpin never does
                  free_slot     = (cur_ff.cls.kind == OP_RELEASE) && (cnt == CNT_ONE);
               end
            end
         end
         default: res.status = ST_ERROR;
      endcase
   end

   assign res_data = res;

   always_comb begin
      used_in  = used_ff;
      valid_in = valid_ff;
      count_in = count_ff;
      if (commit) begin
         if (cnt_we) begin
            count_in[act_idx] = cnt_new;
         end
         if (claim) begin
            used_in[act_idx] = 1'b1;
         end
         if (free_slot) begin
            used_in[act_idx] = 1'b0;
         end
         if (set_valid) begin
            valid_in[act_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_LOOK;
         used_ff  <= '0;
         valid_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // Tags and look results carry no reset
   always_ff @(posedge clock) begin
      if (commit && claim) begin
         dev_ff[act_idx] <= cur_ff.req.device;
         blk_ff[act_idx] <= cur_ff.req.block_number;
      end
      if (look_en) begin
         cur_ff      <= q_item;
         hit_any_ff  <= hit_any;
         hit_idx_ff  <= hit_idx;
         free_any_ff <= free_any;
         free_idx_ff <= free_idx;
      end
   end

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_LOOK && q_valid && q_item.cls.kind == OP_GET) |-> $onehot0(hit_vec))
      else $error("tag matches more than one used slot");

   a_claim_unused: assert property (@(posedge clock) disable iff (reset)
      (commit && claim) |-> !used_ff[act_idx])
      else $error("claim of a slot already in use");

   a_freed_zero: assert property (@(posedge clock) disable iff (reset)
      (commit && free_slot) |=> (count_ff[$past(act_idx)] == '0) && !used_ff[$past(act_idx)])
      else $error("freed slot left with a count");

   a_commit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_COMMIT && !res_ready) |=> (state_ff == BK_COMMIT) && $stable(cur_ff))
      else $error("pending request lost while output blocked");

endmodule

`default_nettype wire

// File: hdl/refcounted_block_buffer_cache.sv
// refcounted_block_buffer_cache: top level of the reference counted buffer cache.
// Instantiates rbc_front and rbc_back; holds the response register.
// Depends on rbc_pkg.
//
//   Channel   Ports                            Moves
//   request   req_valid, req_stall, req_data   opcode, device, block_number, slot
//   response  rsp_valid, rsp_stall, rsp_data   slot_out, needs_read, status, count_out
//
// Sequence: the back end handles each request in a look step (tag compare over
//   all slots plus lowest-free search) and a commit step (count update and
//   result), and pops no new request until that commit is done. A request
//   passes the queue write, the look and the commit into the response register.
// Reset: synchronous, active high; clears queue, sequencer, used/valid marks and
//   counts. Tag storage is not reset and is read only on used slots.
// Stalls: a 2-entry queue decouples request intake from the back end; req_stall
//   rises only when it is full. The response register frees the back end as
//   soon as a waiting result is taken.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_block_buffer_cache (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rbc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rbc_pkg::rsp_type      rsp_data
);
   import rbc_pkg::*;

   logic       q_valid;
   q_item_type q_item;
   logic       q_pop;
   logic       res_valid;
   rsp_type    res_data;
   logic       res_ready;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   rbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   rbc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready)
   );

   // Register can load when empty or when its transfer completes this cycle
   assign res_ready = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: tb/sv/rbc_cache_scoreboard_pkg.sv
// Scoreboard for the buffer cache: a cycle-free model of the slot pool plus the
// queue of responses it expects. Depends on rbc_pkg.
`timescale 1ns / 1ps

package rbc_cache_scoreboard_pkg;

   import rbc_pkg::*;

   class cache_scoreboard;

      // Slot pool as the testbench sees it
      bit                used[NUM_SLOTS];
      logic [DEV_W-1:0]  tag_dev[NUM_SLOTS];
      logic [BLK_W-1:0]  tag_blk[NUM_SLOTS];
      bit   [CNT_W-1:0]  refs[NUM_SLOTS];
      bit                data_valid[NUM_SLOTS];

      rsp_type           outstanding[$];
      int                errors;

      // Apply one accepted request to the pool and queue its response.
      function void note_request(req_type r);
         rsp_type want;
         int      hit;
         int      free_idx;
         int      s;
         want     = '0;
         hit      = -1;
         free_idx = -1;
         if (op_type'(r.opcode) == OP_GET) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (hit < 0 && used[i] && tag_dev[i] == r.device &&
                   tag_blk[i] == r.block_number) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               want.slot_out = SLOT_W'(hit);
               if (refs[hit] == CNT_MAX) begin
                  want.status    = ST_ERROR;
                  want.count_out = CNT_MAX;
               end else begin
                  refs[hit]       = refs[hit] + 1'b1;
                  want.needs_read = !data_valid[hit];
                  data_valid[hit] = 1'b1;
                  want.status     = ST_OK;
                  want.count_out  = refs[hit];
               end
            end else begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (free_idx < 0 && !used[i]) free_idx = i;
               end
               if (free_idx >= 0) begin
                  // claim the free slot: write its tag, set its count to one and mark its data valid
                  used[free_idx]       = 1'b1;
                  tag_dev[free_idx]    = r.device;
                  tag_blk[free_idx]    = r.block_number;
                  refs[free_idx]       = CNT_ONE;
                  data_valid[free_idx] = 1'b1;
                  want.slot_out        = SLOT_W'(free_idx);
                  want.needs_read      = 1'b1;
                  want.status          = ST_OK;
                  want.count_out       = CNT_ONE;
               end else begin
                  want.status = ST_NO_FREE;
               end
            end
         end else begin
            s             = int'(r.slot);
            want.slot_out = r.slot;
            if (s >= NUM_SLOTS) begin
               want.status = ST_ERROR;
            end else if (!used[s]) begin
               want.status    = ST_ERROR;
               want.count_out = refs[s];
            end else if (op_type'(r.opcode) == OP_PIN) begin
               if (refs[s] == CNT_MAX) begin
                  want.status    = ST_ERROR;
                  want.count_out = CNT_MAX;
               end else begin
                  refs[s]        = refs[s] + 1'b1;
                  want.status    = ST_OK;
                  want.count_out = refs[s];
               end
            end else begin
               if (refs[s] == '0) begin
                  want.status = ST_ERROR;
               end else begin
                  refs[s] = refs[s] - 1'b1;
                  // only release frees; unpin may park a used slot at zero
                  if (op_type'(r.opcode) == OP_RELEASE && refs[s] == '0) used[s] = 1'b0;
                  want.status    = ST_OK;
                  want.count_out = refs[s];
               end
            end
         end
         outstanding.push_back(want);
      endfunction

      // Compare one accepted response against the oldest expectation.
      function void check_response(rsp_type got);
         rsp_type want;
         if (outstanding.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = outstanding.pop_front();
         if (got.slot_out !== want.slot_out) begin
            $display("%0t: slot_out expected %0d, actual %0d", $time, want.slot_out,
                     got.slot_out);
            errors++;
         end
         if (got.needs_read !== want.needs_read) begin
            $display("%0t: needs_read expected %0d, actual %0d", $time, want.needs_read,
                     got.needs_read);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status,
                     got.status);
            errors++;
         end
         if (got.count_out !== want.count_out) begin
            $display("%0t: count_out expected %0d, actual %0d", $time, want.count_out,
                     got.count_out);
            errors++;
         end
      endfunction

      // Random slot that currently holds a tag, or -1 when the pool is empty.
      function int pick_used();
         int live[$];
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (used[i]) live.push_back(i);
         end
         if (live.size() == 0) return -1;
         return live[$urandom_range(live.size() - 1)];
      endfunction

   endclass

endpackage

// File: tb/sv/refcounted_block_buffer_cache_test.sv
// Testbench top for refcounted_block_buffer_cache: directed and random request
// streams under varying back-pressure, checked against cache_scoreboard.
// Depends on rbc_pkg, rbc_cache_scoreboard_pkg and the block's RTL.
`timescale 1ns / 1ps

module refcounted_block_buffer_cache_test;

   import rbc_pkg::*;
   import rbc_cache_scoreboard_pkg::*;

   // Quiet cycles allowed before the run is declared hung. The slowest
   // legal stretch is a receiver stall run at 86 percent.
   localparam int QUIET_LIMIT  = 2000;
   // Idle tail after the drain, to allow a little slack.
   localparam int TAIL_CYCLES  = 8;
   localparam int POOL_TAGS    = 48;   // more tags than slots, so the pool can fill
   localparam int ITEMS_PHASE  = 75;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int send_idle_pct = 24;
   int recv_idle_pct = 86;
   int quiet_cycles  = 0;

   logic [DEV_W-1:0] pool_dev[POOL_TAGS];
   logic [BLK_W-1:0] pool_blk[POOL_TAGS];

   cache_scoreboard sb = new();

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   refcounted_block_buffer_cache uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Response side: check every completed transfer, then pick next cycle's stall.
   // Values read here are the ones present at the edge, before any update.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog, no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offer one request, with random idle cycles first; returns at the edge
   // where the transfer happens. Valid is only written once per edge.
   task automatic issue(op_type op, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                        logic [SLOT_W-1:0] slot);
      req_type r;
      r.opcode       = op;
      r.device       = dev;
      r.block_number = blk;
      r.slot         = slot;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
   endtask

   // One random request. Gets mostly reuse the tag pool so hits, refills and
   // a full pool all happen; slot ops mostly aim at slots holding a tag.
   task automatic random_request(int get_pct, int release_pct, int pin_pct);
      int               roll;
      int               pick;
      op_type           op;
      logic [DEV_W-1:0] dev;
      logic [BLK_W-1:0] blk;
      logic [SLOT_W-1:0] slot;
      roll = $urandom_range(99);
      dev  = DEV_W'($urandom);
      blk  = $urandom;
      slot = SLOT_W'($urandom);
      if (roll < get_pct) begin
         op = OP_GET;
         if ($urandom_range(9) != 0) begin
            pick = $urandom_range(POOL_TAGS - 1);
            dev  = pool_dev[pick];
            blk  = pool_blk[pick];
         end
      end else begin
         if (roll < get_pct + release_pct) begin
            op = OP_RELEASE;
         end else if (roll < get_pct + release_pct + pin_pct) begin
            op = OP_PIN;
         end else begin
            op = OP_UNPIN;
         end
         if ($urandom_range(4) != 0) begin
            pick = sb.pick_used();
            if (pick >= 0) slot = SLOT_W'(pick);
         end
      end
      issue(op, dev, blk, slot);
   endtask

   initial begin
      // tag pool: extremes first, the rest random
      pool_dev[0] = '0;
      pool_blk[0] = '0;
      pool_dev[1] = '1;
      pool_blk[1] = '1;
      for (int i = 2; i < POOL_TAGS; i++) begin
         pool_dev[i] = DEV_W'($urandom);
         pool_blk[i] = $urandom;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- Phase 1: sender idles lightly, receiver stalls heavily ----
      send_idle_pct = 24;
      recv_idle_pct = 86;

      // slot operations on an empty pool are all errors
      issue(OP_RELEASE, '0, '0, 5'd0);
      issue(OP_PIN,     '1, '1, 5'd31);
      issue(OP_UNPIN,   8'h55, 32'hAAAA_5555, 5'd17);
      // first claims land on the lowest free slots, both need a read
      issue(OP_GET,     '0, '0, '1);                       // slot 0
      issue(OP_GET,     '1, '1, '0);                       // slot 1
      // hit: count goes up, data already valid
      issue(OP_GET,     '0, '0, 5'd10);
      issue(OP_PIN,     8'hAA, 32'h5555_AAAA, 5'd1);
      issue(OP_UNPIN,   '0, '0, 5'd1);
      issue(OP_UNPIN,   '0, '0, 5'd1);                     // used slot parked at zero
      issue(OP_UNPIN,   '0, '0, 5'd1);                     // underflow
      issue(OP_RELEASE, '0, '0, 5'd1);                     // underflow
      issue(OP_GET,     '1, '1, 5'd3);                     // hit on a zero count
      issue(OP_RELEASE, '0, '0, 5'd1);                     // drops to zero, slot freed
      issue(OP_RELEASE, '0, '0, 5'd1);                     // freed slot is unused
      // freed slot is reclaimed under a new tag and needs a fresh read
      issue(OP_GET,     8'h5A, 32'hA5A5_5A5A, 5'd0);
      issue(OP_RELEASE, '1, '1, 5'd0);
      issue(OP_RELEASE, '1, '1, 5'd0);                     // slot 0 free again

      // Count saturation on slot 0: pin up to the maximum, then one more pin
      // and one more get on the same tag must both be refused.
      issue(OP_GET, 8'hC3, 32'h0000_FFFF, 5'd0);
      repeat (int'(CNT_MAX) - 1) issue(OP_PIN, DEV_W'($urandom), $urandom, 5'd0);
      issue(OP_PIN, DEV_W'($urandom), $urandom, 5'd0);
      issue(OP_GET, 8'hC3, 32'h0000_FFFF, SLOT_W'($urandom));
      issue(OP_RELEASE, DEV_W'($urandom), $urandom, 5'd0);

      // get heavy, so the pool fills and misses find no free slot
      repeat (ITEMS_PHASE) random_request(65, 12, 12);

      // ---- Phase 2: sender idles heavily, receiver rarely stalls ----
      send_idle_pct = 86;
      recv_idle_pct = 24;
      repeat (ITEMS_PHASE) random_request(45, 25, 15);

      // ---- Phase 3: back to back on both sides ----
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (ITEMS_PHASE) random_request(35, 35, 15);

      req_valid <= 1'b0;

      // drain; the watchdog bounds this wait
      while (sb.outstanding.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.outstanding.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/rbc_pkg.sv
hdl/rbc_front.sv
hdl/rbc_back.sv
hdl/refcounted_block_buffer_cache.sv
tb/sv/rbc_cache_scoreboard_pkg.sv
tb/sv/refcounted_block_buffer_cache_test.sv
